@@ src/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the push-to-talk session controller.
// ----------------------------------------------------------------------------
package ptt_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_LINK_UP     = 3'd1,
    CMD_LINK_DOWN   = 3'd2,
    CMD_AUDIO_START = 3'd3,
    CMD_AUDIO_END   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_MS       = 3'd0,
    REG_SPEECH_THRESHOLD  = 3'd1,
    REG_MAX_SESSION_MS    = 3'd2,
    REG_MIN_SESSION_MS    = 3'd3,
    REG_SILENCE_MS        = 3'd4,
    REG_BUTTON_ACTIVE_LOW = 3'd5
  } reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] speech_threshold;
    logic [31:0] max_session_ms;
    logic [31:0] min_session_ms;
    logic [31:0] silence_ms;
    logic        button_active_low;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic        pin_level;
    logic [15:0] rms;
  } item_t;

  typedef struct packed {
    logic        session_started;
    logic        session_refused;
    logic        session_ended;
    logic        session_aborted;
    logic        recording;
    logic [31:0] session_number;
    logic        button_pressed;
  } result_t;

endpackage

@@ src/ptt_cfg.sv @@
// ----------------------------------------------------------------------------
// ptt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ptt_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptt_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ptt_pkg::cfg_t                cfg_o
);

  ptt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ptt_pkg::reg_e'(cfg_idx_i))
        ptt_pkg::REG_DEBOUNCE_MS:       cfg_d.debounce_ms       = cfg_wdata_i[15:0];
        ptt_pkg::REG_SPEECH_THRESHOLD:  cfg_d.speech_threshold  = cfg_wdata_i[15:0];
        ptt_pkg::REG_MAX_SESSION_MS:    cfg_d.max_session_ms    = cfg_wdata_i;
        ptt_pkg::REG_MIN_SESSION_MS:    cfg_d.min_session_ms    = cfg_wdata_i;
        ptt_pkg::REG_SILENCE_MS:        cfg_d.silence_ms        = cfg_wdata_i;
        ptt_pkg::REG_BUTTON_ACTIVE_LOW: cfg_d.button_active_low = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= 16'd30;
      cfg_q.speech_threshold  <= 16'd500;
      cfg_q.max_session_ms    <= 32'd15000;
      cfg_q.min_session_ms    <= 32'd500;
      cfg_q.silence_ms        <= 32'd900;
      cfg_q.button_active_low <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/ptt_core.sv @@
// ----------------------------------------------------------------------------
// ptt_core
// Session state and the single-pass update for one word.
// ----------------------------------------------------------------------------
module ptt_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  ptt_pkg::item_t   item_i,
  input  ptt_pkg::cfg_t    cfg_i,
  output ptt_pkg::result_t result_o
);

  logic        raw_pressed_q, raw_pressed_d;
  logic        stable_pressed_q, stable_pressed_d;
  logic [31:0] last_change_q, last_change_d;
  logic        link_up_q, link_up_d;
  logic        playing_q, playing_d;
  logic        active_q, active_d;
  logic        heard_q, heard_d;
  logic [31:0] start_time_q, start_time_d;
  logic [31:0] last_speech_q, last_speech_d;
  logic [31:0] count_q, count_d;

  logic        pressed;
  logic        accept_press;
  logic        can_start;
  logic        started, refused, ended, aborted;
  logic        speech;
  logic        active_mid;
  logic [31:0] dur;
  logic [31:0] quiet;
  logic        done;

  always_comb begin
    raw_pressed_d    = raw_pressed_q;
    stable_pressed_d = stable_pressed_q;
    last_change_d    = last_change_q;
    link_up_d        = link_up_q;
    playing_d        = playing_q;
    active_d         = active_q;
    heard_d          = heard_q;
    start_time_d     = start_time_q;
    last_speech_d    = last_speech_q;
    count_d          = count_q;
    started          = 1'b0;
    refused          = 1'b0;
    ended            = 1'b0;
    aborted          = 1'b0;

    pressed      = cfg_i.button_active_low ? !item_i.pin_level : item_i.pin_level;
    can_start    = link_up_q && !active_q && !playing_q;
    speech       = item_i.rms >= cfg_i.speech_threshold;
    accept_press = 1'b0;
    active_mid   = 1'b0;
    dur          = '0;
    quiet        = '0;
    done         = 1'b0;

    unique case (ptt_pkg::cmd_e'(item_i.command))
      ptt_pkg::CMD_TICK: begin
        if (pressed != raw_pressed_q) begin
          raw_pressed_d = pressed;
          last_change_d = item_i.now_ms;
        end
        accept_press = (pressed != stable_pressed_q) &&
                       ((item_i.now_ms - last_change_d) >= {16'd0, cfg_i.debounce_ms});
        if (accept_press) begin
          stable_pressed_d = pressed;
          if (pressed) begin
            if (can_start) begin
              started       = 1'b1;
              count_d       = count_q + 32'd1;
              heard_d       = 1'b0;
              start_time_d  = item_i.now_ms;
              last_speech_d = item_i.now_ms;
            end else begin
              refused = 1'b1;
            end
          end
        end
        active_mid = active_q || started;
        if (active_mid) begin
          if (speech) begin
            heard_d       = 1'b1;
            last_speech_d = item_i.now_ms;
          end
          dur   = item_i.now_ms - start_time_d;
          quiet = item_i.now_ms - last_speech_d;
          done  = (dur >= cfg_i.max_session_ms) ||
                  (heard_d && (dur >= cfg_i.min_session_ms) && (quiet >= cfg_i.silence_ms));
          ended    = done;
          active_d = !done;
        end
      end
      ptt_pkg::CMD_LINK_UP: begin
        link_up_d = 1'b1;
      end
      ptt_pkg::CMD_LINK_DOWN: begin
        link_up_d = 1'b0;
        playing_d = 1'b0;
        aborted   = active_q;
        active_d  = 1'b0;
      end
      ptt_pkg::CMD_AUDIO_START: begin
        playing_d = 1'b1;
      end
      ptt_pkg::CMD_AUDIO_END: begin
        playing_d = 1'b0;
      end
      default: ;
    endcase

    result_o.session_started = started;
    result_o.session_refused = refused;
    result_o.session_ended   = ended;
    result_o.session_aborted = aborted;
    result_o.recording       = active_d;
    result_o.session_number  = count_d;
    result_o.button_pressed  = stable_pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_pressed_q    <= 1'b0;
      stable_pressed_q <= 1'b0;
      last_change_q    <= '0;
      link_up_q        <= 1'b0;
      playing_q        <= 1'b0;
      active_q         <= 1'b0;
      heard_q          <= 1'b0;
      start_time_q     <= '0;
      last_speech_q    <= '0;
      count_q          <= '0;
    end else if (step_i) begin
      raw_pressed_q    <= raw_pressed_d;
      stable_pressed_q <= stable_pressed_d;
      last_change_q    <= last_change_d;
      link_up_q        <= link_up_d;
      playing_q        <= playing_d;
      active_q         <= active_d;
      heard_q          <= heard_d;
      start_time_q     <= start_time_d;
      last_speech_q    <= last_speech_d;
      count_q          <= count_d;
    end
  end

endmodule

@@ src/push_to_talk_session_controller.sv @@
// ----------------------------------------------------------------------------
// push_to_talk_session_controller
// Push-to-talk session control: button debounce, session start and refusal,
// speech tracking, timed end and abort on link loss.
//
// channel   direction  handshake               payload
// input     in         in_valid_i / in_stall_o  command, now_ms, pin_level, rms
// result    out        out_valid_o / out_stall_i session flags, number, button
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// one word per cycle while the result side does not stall; a taken word passes the
// input register, then its update is registered into the result register
// an empty input register takes a word while a finished result waits
// a result side stall holds the result register; with a word in the input
// register that word is held too and in_stall_o is raised
// reset clears all session state and loads the register defaults
// ----------------------------------------------------------------------------
module push_to_talk_session_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic [31:0]                  now_ms_i,
  input  logic                         pin_level_i,
  input  logic [15:0]                  rms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         session_started_o,
  output logic                         session_refused_o,
  output logic                         session_ended_o,
  output logic                         session_aborted_o,
  output logic                         recording_o,
  output logic [31:0]                  session_number_o,
  output logic                         button_pressed_o
);

  ptt_pkg::cfg_t    cfg;
  ptt_pkg::item_t   item_q;
  ptt_pkg::result_t result;
  ptt_pkg::result_t out_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  ptt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.command   <= command_i;
      item_q.now_ms    <= now_ms_i;
      item_q.pin_level <= pin_level_i;
      item_q.rms       <= rms_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign session_started_o = out_q.session_started;
  assign session_refused_o = out_q.session_refused;
  assign session_ended_o   = out_q.session_ended;
  assign session_aborted_o = out_q.session_aborted;
  assign recording_o       = out_q.recording;
  assign session_number_o  = out_q.session_number;
  assign button_pressed_o  = out_q.button_pressed;

endmodule

@@ src/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the session controller, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        session_started_o,
  input logic        session_refused_o,
  input logic        session_ended_o,
  input logic        session_aborted_o,
  input logic        recording_o,
  input logic        button_pressed_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // start and abort come from different commands
  a_start_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(session_started_o && session_aborted_o))
    else $error("start and abort in one word");

  // a started session is recording unless it ended on the same tick
  a_start_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && session_started_o |-> recording_o || session_ended_o)
    else $error("started session not recording");

  // ended or aborted session is no longer recording
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (session_ended_o || session_aborted_o) |-> !recording_o)
    else $error("recording after session stop");

  // start or refusal only follows an accepted press
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (session_started_o || session_refused_o) |-> button_pressed_o)
    else $error("session decision without press");

endmodule

bind push_to_talk_session_controller ptt_checker u_ptt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .session_started_o (session_started_o),
  .session_refused_o (session_refused_o),
  .session_ended_o   (session_ended_o),
  .session_aborted_o (session_aborted_o),
  .recording_o       (recording_o),
  .button_pressed_o  (button_pressed_o)
);

@@ sim/push_to_talk_session_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_to_talk_session_controller_tb
// Self-checking bench for the push-to-talk session controller. A directed
// table covers debounce, start, refusal, speech end, abort, timestamp wrap,
// zero debounce, start and end on one tick and unused commands. Random
// traffic follows under several register settings, extremes included. Every
// result word is checked in order against an in-bench session model or
// a typed row's value, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module push_to_talk_session_controller_tb;

  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_WORDS   = 185;

  typedef struct {
    bit               is_cfg;
    ptt_pkg::reg_e    idx;
    logic [31:0]      value;
    ptt_pkg::item_t   word;
    bit               typed;
    ptt_pkg::result_t want;
  } step_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [ptt_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [ptt_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic [2:0]                   command_i   = '0;
  logic [31:0]                  now_ms_i    = '0;
  logic                         pin_level_i = 1'b0;
  logic [15:0]                  rms_i       = '0;
  logic                         out_stall_i = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic                         session_started_o;
  logic                         session_refused_o;
  logic                         session_ended_o;
  logic                         session_aborted_o;
  logic                         recording_o;
  logic [31:0]                  session_number_o;
  logic                         button_pressed_o;

  push_to_talk_session_controller uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .now_ms_i          (now_ms_i),
    .pin_level_i       (pin_level_i),
    .rms_i             (rms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .session_started_o (session_started_o),
    .session_refused_o (session_refused_o),
    .session_ended_o   (session_ended_o),
    .session_aborted_o (session_aborted_o),
    .recording_o       (recording_o),
    .session_number_o  (session_number_o),
    .button_pressed_o  (button_pressed_o)
  );

  // session model state
  ptt_pkg::cfg_t setting;
  logic          raw_down, btn_down, link_ok, assist_on, talking, voice_seen;
  logic [31:0]   edge_ms, talk_start_ms, voice_ms, talk_count;

  ptt_pkg::result_t pending_results[$];
  bit               row_typed;
  ptt_pkg::result_t row_want;
  bit               burst = 1'b0;

  int unsigned cycles, mismatches, words_sent, results_seen, reg_writes;
  int unsigned n_started, n_refused, n_ended, n_aborted;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ptt_pkg::result_t session_step(input ptt_pkg::item_t w);
    ptt_pkg::result_t r;
    logic             pressed;
    logic [31:0]      held;
    logic [31:0]      dur;
    logic [31:0]      quiet;
    logic             done;
    r = '0;
    case (w.command)
      ptt_pkg::CMD_TICK: begin
        pressed = setting.button_active_low ? !w.pin_level : w.pin_level;
        if (pressed != raw_down) begin
          raw_down = pressed;
          edge_ms  = w.now_ms;
        end
        held = w.now_ms - edge_ms;
        if (pressed != btn_down && held >= {16'd0, setting.debounce_ms}) begin
          btn_down = pressed;
          if (pressed) begin
            if (!link_ok || talking || assist_on) begin
              r.session_refused = 1'b1;
            end else begin
              talk_count        = talk_count + 32'd1;
              talking           = 1'b1;
              voice_seen        = 1'b0;
              talk_start_ms     = w.now_ms;
              voice_ms          = w.now_ms;
              r.session_started = 1'b1;
            end
          end
        end
        if (talking) begin
          if (w.rms >= setting.speech_threshold) begin
            voice_seen = 1'b1;
            voice_ms   = w.now_ms;
          end
          dur   = w.now_ms - talk_start_ms;
          quiet = w.now_ms - voice_ms;
          done  = dur >= setting.max_session_ms;
          if (voice_seen && dur >= setting.min_session_ms && quiet >= setting.silence_ms)
            done = 1'b1;
          if (done) begin
            talking         = 1'b0;
            r.session_ended = 1'b1;
          end
        end
      end
      ptt_pkg::CMD_LINK_UP: link_ok = 1'b1;
      ptt_pkg::CMD_LINK_DOWN: begin
        link_ok   = 1'b0;
        assist_on = 1'b0;
        if (talking) begin
          talking           = 1'b0;
          r.session_aborted = 1'b1;
        end
      end
      ptt_pkg::CMD_AUDIO_START: assist_on = 1'b1;
      ptt_pkg::CMD_AUDIO_END: assist_on = 1'b0;
      default: ;
    endcase
    r.recording      = talking;
    r.session_number = talk_count;
    r.button_pressed = btn_down;
    return r;
  endfunction

  function automatic ptt_pkg::result_t outcome(input bit st, input bit rf, input bit en,
                                               input bit ab, input bit rc,
                                               input logic [31:0] num, input bit bp);
    ptt_pkg::result_t r;
    r.session_started = st;
    r.session_refused = rf;
    r.session_ended   = en;
    r.session_aborted = ab;
    r.recording       = rc;
    r.session_number  = num;
    r.button_pressed  = bp;
    return r;
  endfunction

  function automatic step_row_t item_row(input logic [2:0] cmd, input logic [31:0] now,
                                         input logic pin, input logic [15:0] rms);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = ptt_pkg::REG_DEBOUNCE_MS;
    r.value  = '0;
    r.word   = {cmd, now, pin, rms};
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic step_row_t typed_row(input logic [2:0] cmd, input logic [31:0] now,
                                          input logic pin, input logic [15:0] rms,
                                          input ptt_pkg::result_t want);
    step_row_t r;
    r       = item_row(cmd, now, pin, rms);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input ptt_pkg::reg_e idx, input logic [31:0] value);
    step_row_t r;
    r        = item_row(ptt_pkg::CMD_TICK, '0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    return r;
  endfunction

  task automatic send_item(input ptt_pkg::item_t w, input bit typed,
                           input ptt_pkg::result_t want);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i   <= w.command;
    now_ms_i    <= w.now_ms;
    pin_level_i <= w.pin_level;
    rms_i       <= w.rms;
    in_valid_i  <= 1'b1;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input ptt_pkg::reg_e idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      ptt_pkg::REG_DEBOUNCE_MS:       setting.debounce_ms       = value[15:0];
      ptt_pkg::REG_SPEECH_THRESHOLD:  setting.speech_threshold  = value[15:0];
      ptt_pkg::REG_MAX_SESSION_MS:    setting.max_session_ms    = value;
      ptt_pkg::REG_MIN_SESSION_MS:    setting.min_session_ms    = value;
      ptt_pkg::REG_SILENCE_MS:        setting.silence_ms        = value;
      ptt_pkg::REG_BUTTON_ACTIVE_LOW: setting.button_active_low = value[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
    end
  endtask

  // result side stall pattern
  initial begin : result_stall
    int unsigned n;
    forever begin
      n = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) || !rst_ni);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    ptt_pkg::result_t got;
    ptt_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {session_started_o, session_refused_o, session_ended_o, session_aborted_o,
               recording_o, session_number_o, button_pressed_o};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %0d: %0h", results_seen, got);
        end else begin
          want = pending_results.pop_front();
          compare_field("session_started", 32'(got.session_started),
                        32'(want.session_started));
          compare_field("session_refused", 32'(got.session_refused),
                        32'(want.session_refused));
          compare_field("session_ended", 32'(got.session_ended), 32'(want.session_ended));
          compare_field("session_aborted", 32'(got.session_aborted),
                        32'(want.session_aborted));
          compare_field("recording", 32'(got.recording), 32'(want.recording));
          compare_field("session_number", got.session_number, want.session_number);
          compare_field("button_pressed", 32'(got.button_pressed),
                        32'(want.button_pressed));
          if (want.session_started) n_started++;
          if (want.session_refused) n_refused++;
          if (want.session_ended) n_ended++;
          if (want.session_aborted) n_aborted++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = session_step({command_i, now_ms_i, pin_level_i, rms_i});
        if (row_typed)
          want = row_want;
        pending_results.push_back(want);
        words_sent++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t      rows[$];
    ptt_pkg::item_t w;
    logic [31:0]    clock_ms;
    logic           held_pin;
    int unsigned    step_max, pick;
    logic [31:0]    v_deb, v_thr, v_max, v_min, v_sil, v_low;

    setting.debounce_ms       = 16'd30;
    setting.speech_threshold  = 16'd500;
    setting.max_session_ms    = 32'd15000;
    setting.min_session_ms    = 32'd500;
    setting.silence_ms        = 32'd900;
    setting.button_active_low = 1'b1;
    raw_down      = 1'b0;
    btn_down      = 1'b0;
    link_ok       = 1'b0;
    assist_on     = 1'b0;
    talking       = 1'b0;
    voice_seen    = 1'b0;
    edge_ms       = '0;
    talk_start_ms = '0;
    voice_ms      = '0;
    talk_count    = '0;

    // defaults after reset, active-low button
    rows.push_back(typed_row(ptt_pkg::CMD_TICK, 32'd0, 1'b1, 16'd0,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0)));
    rows.push_back(typed_row(ptt_pkg::CMD_TICK, 32'd10, 1'b0, 16'd0,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0)));
    rows.push_back(typed_row(ptt_pkg::CMD_TICK, 32'd40, 1'b0, 16'd0,
                             outcome(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1)));
    rows.push_back(typed_row(ptt_pkg::CMD_LINK_UP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1)));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd50, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd80, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd90, 1'b0, 16'd0));
    rows.push_back(typed_row(ptt_pkg::CMD_TICK, 32'd120, 1'b0, 16'd0,
                             outcome(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'd1, 1'b1)));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd200, 1'b0, 16'hFFFF));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd1200, 1'b0, 16'd0));
    // refused while assistant audio plays
    rows.push_back(item_row(ptt_pkg::CMD_AUDIO_START, 32'd0, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd1300, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd1400, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd1500, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'd1600, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_AUDIO_END, 32'd0, 1'b0, 16'd0));
    rows.push_back(item_row(CMD_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    rows.push_back(item_row(ptt_pkg::CMD_LINK_DOWN, 32'd0, 1'b0, 16'd0));
    // zero debounce, zero max: start and end on one tick
    rows.push_back(cfg_row(ptt_pkg::REG_DEBOUNCE_MS, 32'd0));
    rows.push_back(cfg_row(ptt_pkg::REG_MAX_SESSION_MS, 32'd0));
    rows.push_back(cfg_row(ptt_pkg::REG_BUTTON_ACTIVE_LOW, 32'd0));
    rows.push_back(cfg_row(ptt_pkg::REG_SPEECH_THRESHOLD, 32'hFFFF));
    rows.push_back(item_row(ptt_pkg::CMD_LINK_UP, 32'd0, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'hFFFF_FFF0, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    // refusal and silence end on one tick, across the timestamp wrap
    rows.push_back(cfg_row(ptt_pkg::REG_MAX_SESSION_MS, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(ptt_pkg::REG_MIN_SESSION_MS, 32'd0));
    rows.push_back(cfg_row(ptt_pkg::REG_SILENCE_MS, 32'd100));
    rows.push_back(cfg_row(ptt_pkg::REG_SPEECH_THRESHOLD, 32'd1000));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'hFFFF_FF4E, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'hFFFF_FF80, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'hFFFF_FF8A, 1'b0, 16'd5000));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'h0000_0048, 1'b1, 16'd0));
    // abort on link loss
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'h0000_0100, 1'b0, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_TICK, 32'h0000_0101, 1'b1, 16'd0));
    rows.push_back(item_row(ptt_pkg::CMD_LINK_DOWN, 32'd0, 1'b0, 16'd0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].value);
        cfg_we_i <= 1'b0;
      end else begin
        send_item(rows[i].word, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          v_deb = 20; v_thr = 500; v_max = 3000; v_min = 200; v_sil = 300; v_low = 1;
          step_max = 60;
          clock_ms = 32'hFFFF_F000;
        end
        1: begin
          v_deb = 0; v_thr = 0; v_max = 0; v_min = 0; v_sil = 0; v_low = 0;
          step_max = 40;
          clock_ms = $urandom;
        end
        2: begin
          v_deb = 32'hFFFF; v_thr = 32'hFFFF; v_max = 32'hFFFF_FFFF;
          v_min = 32'hFFFF_FFFF; v_sil = 32'hFFFF_FFFF; v_low = 1;
          step_max = 20000;
          clock_ms = $urandom;
        end
        default: begin
          v_deb = $urandom_range(0, 100);
          v_thr = $urandom_range(0, 65535);
          v_max = $urandom_range(0, 5000);
          v_min = $urandom_range(0, 2000);
          v_sil = $urandom_range(0, 2000);
          v_low = $urandom_range(0, 1);
          step_max = 200;
          clock_ms = $urandom;
        end
      endcase
      drain();
      write_reg(ptt_pkg::REG_DEBOUNCE_MS, v_deb);
      write_reg(ptt_pkg::REG_SPEECH_THRESHOLD, v_thr);
      write_reg(ptt_pkg::REG_MAX_SESSION_MS, v_max);
      write_reg(ptt_pkg::REG_MIN_SESSION_MS, v_min);
      write_reg(ptt_pkg::REG_SILENCE_MS, v_sil);
      write_reg(ptt_pkg::REG_BUTTON_ACTIVE_LOW, v_low);
      cfg_we_i <= 1'b0;
      held_pin = 1'($urandom_range(0, 1));

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 48 == 0)
          burst = ($urandom_range(0, 3) == 0);
        pick        = $urandom_range(0, 99);
        w.now_ms    = $urandom;
        w.pin_level = 1'($urandom_range(0, 1));
        w.rms       = 16'($urandom_range(0, 65535));
        if (pick < 80) begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          if ($urandom_range(0, 99) < 12)
            held_pin = !held_pin;
          w.command   = ptt_pkg::CMD_TICK;
          w.now_ms    = clock_ms;
          w.pin_level = held_pin;
          case ($urandom_range(0, 2))
            0: w.rms = (v_thr == 0) ? 16'd0 : 16'($urandom_range(0, v_thr - 1));
            1: w.rms = 16'($urandom_range(v_thr, 65535));
            default: ;
          endcase
        end else if (pick < 86) begin
          w.command = ptt_pkg::CMD_LINK_UP;
        end else if (pick < 89) begin
          w.command = ptt_pkg::CMD_LINK_DOWN;
        end else if (pick < 92) begin
          w.command = ptt_pkg::CMD_AUDIO_START;
        end else if (pick < 97) begin
          w.command = ptt_pkg::CMD_AUDIO_END;
        end else if (pick < 99) begin
          w.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end else begin
          // time jump
          w.command = ptt_pkg::CMD_TICK;
          clock_ms  = w.now_ms;
        end
        send_item(w, 1'b0, '0);
      end
    end

    burst = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d words and %0d register writes in %0d cycles",
             words_sent, reg_writes, cycles);
    $display("sessions: %0d started, %0d refused, %0d ended, %0d aborted; %0d mismatches",
             n_started, n_refused, n_ended, n_aborted, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
src/ptt_pkg.sv
src/ptt_cfg.sv
src/ptt_core.sv
src/push_to_talk_session_controller.sv
src/ptt_checker.sv
sim/push_to_talk_session_controller_tb.sv
